/* rtl/core/vsre_pkg.sv */
// ----------------------------------------------------------------------------
// Voxel slice RLE encoder package
// Shared types, constants and helper functions for the encoder front end,
// command queue and word sequencer.
// ----------------------------------------------------------------------------
package vsre_pkg;

   localparam int MAX_SIDE    = 1024;
   localparam int SIDE_W      = 11;                  // width of a side register
   localparam int POS_W       = $clog2(MAX_SIDE);    // column and row position
   localparam int SLICE_W     = POS_W + 1;
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 21;
   localparam int CSR_INDEX_W = 3;
   // The queue pointers wrap naturally, so the depth must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [WORD_W-1:0]  CODE_SLICE = WORD_W'(6);
   localparam logic [WORD_W-1:0]  CODE_RUN   = WORD_W'(2);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_DEPTH,
      CSR_RLE_ENABLE,
      CSR_BGRA_ORDER
   } csr_index_type;

   typedef enum logic [1:0] {
      FLUSH_NONE,
      FLUSH_ONE,
      FLUSH_TWO,
      FLUSH_TRIPLE
   } flush_kind_type;

   typedef enum logic [1:0] {
      SEG_A,
      SEG_B,
      SEG_C
   } seg_type;

   typedef struct packed {
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic [SIDE_W-1:0] depth;
      logic              rle_enable;
      logic              bgra_order;
   } cfg_type;

   typedef struct packed {
      flush_kind_type     kind;
      logic [WORD_W-1:0]  value;
      logic [COUNT_W-1:0] count;
   } flush_type;

   // One accepted voxel's work: a run closed by the voxel (or the raw word),
   // the run closed at the end of a slice, and the slice end code.
   typedef struct packed {
      flush_type first;
      flush_type second;
      logic      slice_code;
      logic      matrix_done;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] side_reg);
      logic [SIDE_W-1:0] side;
      if (side_reg == '0) begin
         side = SIDE_W'(1);
      end else if (side_reg > SIDE_W'(MAX_SIDE)) begin
         side = SIDE_W'(MAX_SIDE);
      end else begin
         side = side_reg;
      end
      return side;
   endfunction

   function automatic flush_type make_flush(input logic               open,
                                            input logic [WORD_W-1:0]  value,
                                            input logic [COUNT_W-1:0] count);
      flush_type f;
      f.value = value;
      f.count = count;
      if (!open) begin
         f.kind = FLUSH_NONE;
      end else if (value == CODE_RUN || value == CODE_SLICE || count >= COUNT_W'(3)) begin
         f.kind = FLUSH_TRIPLE;
      end else if (count == COUNT_W'(2)) begin
         f.kind = FLUSH_TWO;
      end else begin
         f.kind = FLUSH_ONE;
      end
      return f;
   endfunction

   function automatic logic [1:0] flush_len(input flush_kind_type kind);
      logic [1:0] len;
      case (kind)
         FLUSH_ONE:    len = 2'd1;
         FLUSH_TWO:    len = 2'd2;
         FLUSH_TRIPLE: len = 2'd3;
         default:      len = 2'd0;
      endcase
      return len;
   endfunction

endpackage

/* rtl/core/vsre_front.sv */
// ----------------------------------------------------------------------------
// Voxel slice RLE encoder front end
// Accepts voxels, tracks the matrix position and the open run, and turns each
// voxel that yields words into a command for the word sequencer.
// ----------------------------------------------------------------------------
module vsre_front (
   input  logic                      clock,
   input  logic                      reset,
   input  vsre_pkg::cfg_type         cfg,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,
   input  vsre_pkg::queue_status_type q_status,
   output logic                      push,
   output vsre_pkg::cmd_type         cmd
);

   logic [vsre_pkg::POS_W-1:0]   col_ff, col_in;
   logic [vsre_pkg::POS_W-1:0]   row_ff, row_in;
   logic [vsre_pkg::SLICE_W-1:0] slice_ff, slice_in;
   logic [vsre_pkg::WORD_W-1:0]  run_value_ff, run_value_in;
   logic [vsre_pkg::COUNT_W-1:0] run_count_ff, run_count_in;
   logic                         run_open_ff, run_open_in;

   logic                         accept;
   logic [vsre_pkg::WORD_W-1:0]  voxel;
   logic [vsre_pkg::SIDE_W-1:0]  w_side, h_side, d_side;
   logic [vsre_pkg::POS_W:0]     col_sum, row_sum;
   logic [vsre_pkg::SLICE_W-1:0] slice_sum;
   logic                         slice_end;
   logic                         matrix_done;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      w_side = vsre_pkg::side_of(cfg.width);
      h_side = vsre_pkg::side_of(cfg.height);
      d_side = vsre_pkg::side_of(cfg.depth);

      if (cfg.bgra_order) begin
         voxel = {req_tdata[31:24], req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      end else begin
         voxel = req_tdata;
      end

      run_value_in = run_value_ff;
      run_count_in = run_count_ff;
      run_open_in  = run_open_ff;
      cmd.first    = vsre_pkg::make_flush(1'b0, voxel, run_count_ff);
      cmd.second   = vsre_pkg::make_flush(1'b0, voxel, run_count_ff);
      cmd.slice_code = 1'b0;

      if (cfg.rle_enable) begin
         if (run_open_ff && run_value_ff == voxel && run_count_ff != vsre_pkg::COUNT_MAX) begin
            run_count_in = run_count_ff + vsre_pkg::COUNT_W'(1);
         end else begin
            cmd.first    = vsre_pkg::make_flush(run_open_ff, run_value_ff, run_count_ff);
            run_open_in  = 1'b1;
            run_value_in = voxel;
            run_count_in = vsre_pkg::COUNT_W'(1);
         end
      end else begin
         // Raw mode drops any open run and passes the voxel straight on.
         run_open_in  = 1'b0;
         run_count_in = '0;
         cmd.first    = vsre_pkg::make_flush(1'b1, voxel, vsre_pkg::COUNT_W'(1));
         // A raw word goes out as it is, even when it equals a code.
         cmd.first.kind = vsre_pkg::FLUSH_ONE;
      end

      // Position advance, each compare against the side as it stands now.
      col_sum   = {1'b0, col_ff} + (vsre_pkg::POS_W + 1)'(1);
      row_sum   = {1'b0, row_ff};
      slice_sum = slice_ff;
      slice_end = 1'b0;
      matrix_done = 1'b0;
      if (col_sum >= w_side) begin
         col_sum = '0;
         row_sum = {1'b0, row_ff} + (vsre_pkg::POS_W + 1)'(1);
      end
      if (row_sum >= h_side) begin
         row_sum   = '0;
         slice_sum = slice_ff + vsre_pkg::SLICE_W'(1);
         slice_end = 1'b1;
      end
      if (slice_sum >= d_side) begin
         slice_sum   = '0;
         col_sum     = '0;
         row_sum     = '0;
         matrix_done = 1'b1;
      end
      col_in   = col_sum[vsre_pkg::POS_W-1:0];
      row_in   = row_sum[vsre_pkg::POS_W-1:0];
      slice_in = slice_sum;

      if (cfg.rle_enable && (slice_end || matrix_done)) begin
         cmd.second     = vsre_pkg::make_flush(run_open_in, run_value_in, run_count_in);
         cmd.slice_code = 1'b1;
         run_open_in    = 1'b0;
         run_count_in   = '0;
      end
      cmd.matrix_done = matrix_done;

      push = accept && (cmd.first.kind != vsre_pkg::FLUSH_NONE || cmd.slice_code);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         slice_ff     <= '0;
         run_value_ff <= '0;
         run_count_ff <= '0;
         run_open_ff  <= 1'b0;
      end else if (accept) begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         slice_ff     <= slice_in;
         run_value_ff <= run_value_in;
         run_count_ff <= run_count_in;
         run_open_ff  <= run_open_in;
      end
   end

endmodule

/* rtl/core/vsre_queue.sv */
// ----------------------------------------------------------------------------
// Voxel slice RLE encoder command queue
// A short first-in first-out store of commands between front end and
// word sequencer.
// ----------------------------------------------------------------------------
module vsre_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vsre_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output vsre_pkg::cmd_type          head,
   output vsre_pkg::queue_status_type status
);

   vsre_pkg::cmd_type             entry_ff [vsre_pkg::QUEUE_DEPTH];
   logic [vsre_pkg::QPTR_W-1:0]   wr_ff, wr_in;
   logic [vsre_pkg::QPTR_W-1:0]   rd_ff, rd_in;
   logic [vsre_pkg::QPTR_W:0]     fill_ff, fill_in;

   always_comb begin
      status.full  = (fill_ff == (vsre_pkg::QPTR_W + 1)'(vsre_pkg::QUEUE_DEPTH));
      status.empty = (fill_ff == '0);
      head         = entry_ff[rd_ff];

      wr_in   = push ? wr_ff + vsre_pkg::QPTR_W'(1) : wr_ff;
      rd_in   = pop  ? rd_ff + vsre_pkg::QPTR_W'(1) : rd_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (vsre_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (vsre_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/vsre_back.sv */
// ----------------------------------------------------------------------------
// Voxel slice RLE encoder word sequencer
// Takes commands from the queue and emits their words one per cycle, while
// the result side is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module vsre_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vsre_pkg::queue_status_type q_status,
   input  vsre_pkg::cmd_type          head,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,  // word
   output logic                       rsp_tlast,
   output logic                       rsp_tuser   // matrix_end
);

   vsre_pkg::seg_type            seg_ff, seg_in, cur_seg;
   logic [1:0]                   sub_ff, sub_in;
   logic                         valid_ff, valid_in;
   logic [vsre_pkg::WORD_W-1:0]  word_ff, word_in;
   logic                         last_ff, last_in;
   logic                         end_ff, end_in;

   logic [1:0]                   len_a, len_b, cur_len;
   vsre_pkg::flush_type          cur_flush;
   logic                         sub_last;
   logic                         is_final;
   logic                         step;

   always_comb begin
      len_a = vsre_pkg::flush_len(head.first.kind);
      len_b = vsre_pkg::flush_len(head.second.kind);

      // A command without a first run starts at the slice-end run.
      if (seg_ff == vsre_pkg::SEG_A && len_a == 2'd0) begin
         cur_seg = vsre_pkg::SEG_B;
      end else begin
         cur_seg = seg_ff;
      end

      unique case (cur_seg)
         vsre_pkg::SEG_A: begin
            cur_flush = head.first;
            cur_len   = len_a;
         end
         vsre_pkg::SEG_B: begin
            cur_flush = head.second;
            cur_len   = len_b;
         end
         default: begin
            cur_flush = head.second;
            cur_len   = 2'd1;
         end
      endcase

      if (cur_seg == vsre_pkg::SEG_C) begin
         word_in = vsre_pkg::CODE_SLICE;
      end else if (cur_flush.kind == vsre_pkg::FLUSH_TRIPLE) begin
         case (sub_ff)
            2'd0:    word_in = vsre_pkg::CODE_RUN;
            2'd1:    word_in = vsre_pkg::WORD_W'(cur_flush.count);
            default: word_in = cur_flush.value;
         endcase
      end else begin
         word_in = cur_flush.value;
      end

      sub_last = (2'(sub_ff + 2'd1) == cur_len);
      is_final = sub_last &&
                 (cur_seg == vsre_pkg::SEG_C ||
                  (cur_seg == vsre_pkg::SEG_B && !head.slice_code) ||
                  (cur_seg == vsre_pkg::SEG_A && len_b == 2'd0 && !head.slice_code));
      last_in  = is_final;
      end_in   = is_final && head.matrix_done;

      step = !q_status.empty && (!valid_ff || rsp_tready);
      pop  = step && is_final;

      seg_in = seg_ff;
      sub_in = sub_ff;
      if (step) begin
         if (is_final) begin
            seg_in = vsre_pkg::SEG_A;
            sub_in = 2'd0;
         end else if (!sub_last) begin
            seg_in = cur_seg;
            sub_in = sub_ff + 2'd1;
         end else begin
            if (cur_seg == vsre_pkg::SEG_A && len_b != 2'd0) begin
               seg_in = vsre_pkg::SEG_B;
            end else begin
               seg_in = vsre_pkg::SEG_C;
            end
            sub_in = 2'd0;
         end
      end

      if (step) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff   <= vsre_pkg::SEG_A;
         sub_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         seg_ff   <= seg_in;
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         word_ff <= word_in;
         last_ff <= last_in;
         end_ff  <= end_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = word_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = end_ff;

endmodule

/* rtl/core/voxel_slice_rle_encoder.sv */
// ----------------------------------------------------------------------------
// Voxel slice RLE encoder
// Encodes a stream of matrix voxels into raw or run-length coded data words.
// ----------------------------------------------------------------------------
// Each voxel's words pass the command queue and the output register.
// Throughput: one voxel per cycle while the queue is not full, one word per
// cycle while rsp_tready is high, set by the single-word sequencer output
// register; a four-entry command queue absorbs bursts of up to seven words.
// Reset is synchronous: it clears the position, the open run and the queue,
// and sets the registers to width 1, height 1, depth 1, raw, red first.
module voxel_slice_rle_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vsre_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vsre_pkg::SIDE_W-1:0]       csr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // red, green, blue, alpha
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // word
   output logic                              rsp_tlast,
   output logic                              rsp_tuser   // matrix_end
);

   vsre_pkg::cfg_type          cfg_ff, cfg_in;
   vsre_pkg::queue_status_type q_status;
   vsre_pkg::cmd_type          push_cmd;
   vsre_pkg::cmd_type          head;
   logic                       push;
   logic                       pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (vsre_pkg::csr_index_type'(csr_index))
            vsre_pkg::CSR_WIDTH:      cfg_in.width      = csr_data;
            vsre_pkg::CSR_HEIGHT:     cfg_in.height     = csr_data;
            vsre_pkg::CSR_DEPTH:      cfg_in.depth      = csr_data;
            vsre_pkg::CSR_RLE_ENABLE: cfg_in.rle_enable = csr_data[0];
            vsre_pkg::CSR_BGRA_ORDER: cfg_in.bgra_order = csr_data[0];
            default:                  cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width      <= vsre_pkg::SIDE_W'(1);
         cfg_ff.height     <= vsre_pkg::SIDE_W'(1);
         cfg_ff.depth      <= vsre_pkg::SIDE_W'(1);
         cfg_ff.rle_enable <= 1'b0;
         cfg_ff.bgra_order <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vsre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .cmd        (push_cmd)
   );

   vsre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   vsre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // A command is never written into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("command pushed into a full queue");

   // The sequencer never takes a command from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("command popped from an empty queue");

   // The end of a matrix is always the last word of its voxel.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("matrix end flagged on a word that is not the last");

   // After reset the queue starts empty and no word is offered.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> q_status.empty && !rsp_tvalid)
      else $error("queue or output not cleared by reset");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Voxel slice RLE encoder testbench
// Streams voxels through the encoder in raw and run-length modes under
// changing matrix sizes and byte orders. Every data word is predicted in the
// bench and checked, word by word, as it leaves the result stream.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vsre_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RANDOM_VOXELS = 80;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int MAX_WORDS     = 7;
   localparam int DIRECTED_N    = 38;

   // Index beyond the register list; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = CSR_INDEX_W'(5);

   typedef enum logic {
      ROW_REG,
      ROW_VOXEL
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [SIDE_W-1:0]       value;
      logic [31:0]             voxel;
      logic                    typed;
      logic [WORD_W-1:0]       want_word;
      logic                    want_end;
   } stim_row_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
      logic              matrix_end;
   } enc_word_type;

   // Rows with a typed word come from a 1x1x1 raw matrix: one word, last set.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      '{ROW_VOXEL, '0, '0, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
      '{ROW_VOXEL, '0, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{ROW_VOXEL, '0, '0, 32'h5AA5_C33C, 1'b1, 32'h5AA5_C33C, 1'b1},
      '{ROW_VOXEL, '0, '0, 32'hA55A_3CC3, 1'b1, 32'hA55A_3CC3, 1'b1},
      '{ROW_REG, CSR_BGRA_ORDER, SIDE_W'(1), '0, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h4433_2211, 1'b1, 32'h4411_2233, 1'b1},
      '{ROW_REG, CSR_BGRA_ORDER, SIDE_W'(0), '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_WIDTH, SIDE_W'(3), '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_HEIGHT, SIDE_W'(2), '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_DEPTH, SIDE_W'(0), '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_UNUSED, '1, '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_RLE_ENABLE, SIDE_W'(1), '0, 1'b0, '0, 1'b0},
      // One slice of six: a run of three, a run of two, a single at slice end.
      '{ROW_VOXEL, '0, '0, 32'h1111_1111, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h1111_1111, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h1111_1111, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h2222_2222, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h2222_2222, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h3333_3333, 1'b0, '0, 1'b0},
      // Values equal to the run and slice codes are always sent as triples.
      '{ROW_VOXEL, '0, '0, 32'h0000_0002, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h0000_0002, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h0000_0006, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h4444_4444, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h5555_5555, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h5555_5555, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_WIDTH, '1, '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_HEIGHT, '1, '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_DEPTH, '1, '0, 1'b0, '0, 1'b0},
      // A run left open when raw mode is selected is dropped silently.
      '{ROW_VOXEL, '0, '0, 32'h7777_7777, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_RLE_ENABLE, SIDE_W'(0), '0, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h8888_8888, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_BGRA_ORDER, SIDE_W'(1), '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_RLE_ENABLE, SIDE_W'(1), '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_WIDTH, SIDE_W'(1), '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_HEIGHT, SIDE_W'(1), '0, 1'b0, '0, 1'b0},
      '{ROW_REG, CSR_DEPTH, SIDE_W'(1), '0, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h0002_0000, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h0000_0006, 1'b0, '0, 1'b0},
      '{ROW_VOXEL, '0, '0, 32'h0006_0000, 1'b0, '0, 1'b0}
   };

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [SIDE_W-1:0]      csr_data   = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = '0;   // red, green, blue, alpha
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;         // word
   logic                   rsp_tlast;
   logic                   rsp_tuser;         // matrix_end

   // Bench copy of the encoder settings and state.
   logic [SIDE_W-1:0]  cfg_width  = SIDE_W'(1);
   logic [SIDE_W-1:0]  cfg_height = SIDE_W'(1);
   logic [SIDE_W-1:0]  cfg_depth  = SIDE_W'(1);
   logic               cfg_rle    = 1'b0;
   logic               cfg_bgra   = 1'b0;
   logic [SIDE_W-1:0]  pos_col    = '0;
   logic [SIDE_W-1:0]  pos_row    = '0;
   logic [SIDE_W-1:0]  pos_slice  = '0;
   logic [WORD_W-1:0]  run_word   = '0;
   logic [COUNT_W-1:0] run_len    = '0;
   logic               run_live   = 1'b0;

   enc_word_type voxel_words [MAX_WORDS];
   int           word_count;
   enc_word_type expected_words [$];

   bit no_idle         = 1'b0;
   int voxels_sent     = 0;
   int directed_voxels = 0;
   int words_checked   = 0;
   int reg_writes      = 0;
   int random_phases   = 0;
   int mismatches      = 0;
   int idle_cycles     = 0;

   voxel_slice_rle_encoder DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic logic [SIDE_W-1:0] side_in_use(input logic [SIDE_W-1:0] reg_value);
      return (reg_value == '0) ? SIDE_W'(1) :
             (reg_value > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : reg_value;
   endfunction

   function automatic void push_word(input logic [WORD_W-1:0] w);
      voxel_words[word_count] = '{w, 1'b0, 1'b0};
      word_count++;
   endfunction

   function automatic void close_run();
      if (!run_live) return;
      if (run_word == CODE_RUN || run_word == CODE_SLICE || run_len >= COUNT_W'(3)) begin
         push_word(CODE_RUN);
         push_word(WORD_W'(run_len));
         push_word(run_word);
      end else begin
         push_word(run_word);
         if (run_len == COUNT_W'(2)) push_word(run_word);
      end
      run_live = 1'b0;
      run_len  = '0;
   endfunction

   // Works out the words one voxel causes and, if asked, queues them.
   function automatic void encode_voxel(input logic [31:0] pixel, input bit keep);
      logic [WORD_W-1:0] w;
      logic              slice_done;
      logic              matrix_done;
      word_count  = 0;
      slice_done  = 1'b0;
      matrix_done = 1'b0;
      w = cfg_bgra ? {pixel[31:24], pixel[7:0], pixel[15:8], pixel[23:16]} : pixel;
      if (cfg_rle) begin
         if (run_live && run_word == w && run_len != COUNT_MAX) begin
            run_len = run_len + 1'b1;
         end else begin
            close_run();
            run_live = 1'b1;
            run_word = w;
            run_len  = COUNT_W'(1);
         end
      end else begin
         run_live = 1'b0;
         run_len  = '0;
         push_word(w);
      end
      pos_col = pos_col + 1'b1;
      if (pos_col >= side_in_use(cfg_width)) begin
         pos_col = '0;
         pos_row = pos_row + 1'b1;
      end
      if (pos_row >= side_in_use(cfg_height)) begin
         pos_row    = '0;
         pos_slice  = pos_slice + 1'b1;
         slice_done = 1'b1;
      end
      if (pos_slice >= side_in_use(cfg_depth)) begin
         pos_slice   = '0;
         pos_col     = '0;
         pos_row     = '0;
         matrix_done = 1'b1;
      end
      if (cfg_rle && (slice_done || matrix_done)) begin
         close_run();
         push_word(CODE_SLICE);
      end
      if (word_count > 0) begin
         voxel_words[word_count-1].last       = 1'b1;
         voxel_words[word_count-1].matrix_end = matrix_done;
      end
      if (keep) begin
         for (int i = 0; i < word_count; i++) expected_words.push_back(voxel_words[i]);
      end
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [SIDE_W-1:0] value);
      case (index)
         CSR_WIDTH:      cfg_width  = value;
         CSR_HEIGHT:     cfg_height = value;
         CSR_DEPTH:      cfg_depth  = value;
         CSR_RLE_ENABLE: cfg_rle    = value[0];
         CSR_BGRA_ORDER: cfg_bgra   = value[0];
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("Mismatch: %s", msg);
   endfunction

   function automatic logic [SIDE_W-1:0] pick_side();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       return '0;
         1:       return SIDE_W'(MAX_SIDE);
         2:       return '1;
         3:       return SIDE_W'($urandom_range(0, 2047));
         default: return SIDE_W'($urandom_range(1, 4));
      endcase
   endfunction

   // Repeats half the time, so that runs of various lengths form inside a slice.
   function automatic logic [31:0] next_voxel(input logic [31:0] prev);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return prev;
      if (roll == 5) begin
         case ($urandom_range(0, 3))
            0:       return CODE_RUN;
            1:       return CODE_SLICE;
            2:       return {CODE_RUN[15:0], 16'h0000};
            default: return {CODE_SLICE[15:0], 16'h0000};
         endcase
      end
      if (roll == 6) return prev ^ (32'h1 << $urandom_range(0, 31));
      return $urandom;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [SIDE_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(index, value);
      reg_writes++;
   endtask

   task automatic send_voxel(input logic [31:0] pixel, input bit typed,
                             input logic [WORD_W-1:0] want_word, input logic want_end);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // Predict before the request goes out, so the words are queued in time.
      if (typed) expected_words.push_back('{want_word, 1'b1, want_end});
      encode_voxel(pixel, !typed);
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
      voxels_sent++;
   endtask

   // Registers change only once every word is out and a voxel that caused
   // none has had time to pass through the command queue.
   task automatic settle_for_regs();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int           stall;
      enc_word_type got;
      enc_word_type want;
      wait (!reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = '{rsp_tdata, rsp_tlast, rsp_tuser};
         if (expected_words.size() == 0) begin
            note_mismatch($sformatf("word %h last %b end %b with nothing expected",
                                    got.word, got.last, got.matrix_end));
         end else begin
            want = expected_words.pop_front();
            if (got.word !== want.word || got.last !== want.last ||
                got.matrix_end !== want.matrix_end) begin
               note_mismatch($sformatf("word %0d expected %h last %b end %b, got %h last %b end %b",
                                       words_checked, want.word, want.last, want.matrix_end,
                                       got.word, got.last, got.matrix_end));
            end
         end
         words_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no request or word moved for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [31:0] pixel;
      int          phase_len;
      bit          after_voxel;
      after_voxel = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_N; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_REG) begin
            if (after_voxel) settle_for_regs();
            after_voxel = 1'b0;
            write_reg(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].value);
         end else begin
            send_voxel(DIRECTED_ROWS[i].voxel, DIRECTED_ROWS[i].typed,
                       DIRECTED_ROWS[i].want_word, DIRECTED_ROWS[i].want_end);
            after_voxel = 1'b1;
         end
      end
      directed_voxels = voxels_sent;

      pixel = $urandom;
      while (voxels_sent < directed_voxels + RANDOM_VOXELS) begin
         settle_for_regs();
         no_idle = ($urandom_range(0, 3) == 0);
         // Registers left alone keep the matrix position running across phases.
         if ($urandom_range(0, 3) != 0) write_reg(CSR_WIDTH, pick_side());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_HEIGHT, pick_side());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_DEPTH, pick_side());
         if ($urandom_range(0, 3) != 0)
            write_reg(CSR_RLE_ENABLE, SIDE_W'($urandom_range(0, 2) != 0));
         if ($urandom_range(0, 3) != 0)
            write_reg(CSR_BGRA_ORDER, SIDE_W'($urandom_range(0, 1)));
         phase_len = $urandom_range(6, 20);
         repeat (phase_len) begin
            pixel = next_voxel(pixel);
            send_voxel(pixel, 1'b0, '0, 1'b0);
         end
         random_phases++;
      end
      no_idle = 1'b0;
      settle_for_regs();

      $display("Sent %0d voxels (%0d directed, rest in %0d random phases) and %0d register writes.",
               voxels_sent, directed_voxels, random_phases, reg_writes);
      $display("Checked %0d words, %0d mismatches.", words_checked, mismatches);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
